@@ rtl/pair_force_table_interpolator_assert.svh @@
// ---------------------------------------------------------------------------
// pair force table interpolator assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef PAIR_FORCE_TABLE_INTERPOLATOR_ASSERT_SVH
`define PAIR_FORCE_TABLE_INTERPOLATOR_ASSERT_SVH

// condition and consequence in the same cycle
`define PFT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define PFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pft_pkg.sv @@
// ---------------------------------------------------------------------------
// pft_pkg
// shared constants, register codes and pipeline control type
// ---------------------------------------------------------------------------
package pft_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int DIST_BITS      = 24;
	localparam int STEP_BITS      = 32;
	localparam int COUNT_BITS     = 11;
	localparam int INDEX_BITS     = 10;
	localparam int POS_FRAC_BITS  = 32;
	localparam int PROD_BITS      = DIST_BITS + STEP_BITS;
	localparam int KIDX_BITS      = PROD_BITS - POS_FRAC_BITS;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DISTANCE   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERSE_STEP   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRIES_IN_USE = 2'd2;

	localparam logic [DIST_BITS-1:0]  MIN_DISTANCE_RST   = 24'd0;
	localparam logic [STEP_BITS-1:0]  INVERSE_STEP_RST   = 32'h0001_0000;
	localparam logic [COUNT_BITS-1:0] ENTRIES_IN_USE_RST = 11'd1024;

	typedef struct packed {
		logic valid;
		logic query;
		logic below;
		logic zero;
		logic wr_ok;
	} ctl_t;

endpackage

@@ rtl/pft_in_if.sv @@
// ---------------------------------------------------------------------------
// pft_in_if
// input channel: load and query items
// ---------------------------------------------------------------------------
interface pft_in_if #(
	parameter int VALUE_BITS = pft_pkg::VALUE_BITS_DEF
);
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [pft_pkg::INDEX_BITS-1:0]      entry_index;
	logic signed [VALUE_BITS-1:0]        load_force;
	logic signed [VALUE_BITS-1:0]        load_energy;
	logic [pft_pkg::DIST_BITS-1:0]       distance;

	modport source (output valid, kind, entry_index, load_force, load_energy, distance,
		input ready);
	modport sink (input valid, kind, entry_index, load_force, load_energy, distance,
		output ready);
endinterface

@@ rtl/pft_out_if.sv @@
// ---------------------------------------------------------------------------
// pft_out_if
// result channel: interpolated force and energy
// ---------------------------------------------------------------------------
interface pft_out_if #(
	parameter int VALUE_BITS = pft_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] force_res;
	logic signed [VALUE_BITS-1:0] energy;

	modport source (output valid, force_res, energy, input ready);
	modport sink (input valid, force_res, energy, output ready);
endinterface

@@ rtl/pft_cfg_if.sv @@
// ---------------------------------------------------------------------------
// pft_cfg_if
// register write channel
// ---------------------------------------------------------------------------
interface pft_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pft_pkg::CFG_INDEX_BITS-1:0] index;
	logic [pft_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pft_ram.sv @@
// ---------------------------------------------------------------------------
// pft_ram
// generic ram, one write port, two registered read ports
// ---------------------------------------------------------------------------
module pft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr_a,
	input  logic [ADDR_BITS-1:0] raddr_b,
	output logic [WIDTH-1:0]     rdata_a,
	output logic [WIDTH-1:0]     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ rtl/pft_front.sv @@
// ---------------------------------------------------------------------------
// pft_front
// stages 1 to 3: offset from minimum, position multiply, entry and fraction
// ---------------------------------------------------------------------------
`include "pair_force_table_interpolator_assert.svh"

module pft_front #(
	parameter int TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_BITS  = pft_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS   = pft_pkg::FRAC_BITS_DEF,
	localparam int ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pft_in_if.sink                              req,
	input  logic [pft_pkg::DIST_BITS-1:0]       min_distance,
	input  logic [pft_pkg::STEP_BITS-1:0]       inverse_step,
	input  logic [pft_pkg::COUNT_BITS-1:0]      entries_in_use,
	input  logic                                take,
	output pft_pkg::ctl_t                       ctl_s3,
	output logic [FRAC_BITS-1:0]                frac_s3,
	output logic [ADDR_BITS-1:0]                addr_lo_s3,
	output logic [ADDR_BITS-1:0]                addr_hi_s3,
	output logic [ADDR_BITS-1:0]                wr_addr_s3,
	output logic [VALUE_BITS-1:0]               force_s3,
	output logic [VALUE_BITS-1:0]               energy_s3
);

	localparam int KB = pft_pkg::KIDX_BITS;

	pft_pkg::ctl_t ctl_s1, ctl_s2, ctl_in, ctl_nx3;
	logic en1, en2, en3;

	logic [pft_pkg::INDEX_BITS-1:0] idx_s1, idx_s2;
	logic [VALUE_BITS-1:0]          force_s1, force_s2, energy_s1, energy_s2;
	logic [pft_pkg::DIST_BITS-1:0]  pos_s1;
	logic [pft_pkg::PROD_BITS-1:0]  prod_s2;

	logic [KB-1:0] n_ext, n_cap, lim, k, k1;
	logic [FRAC_BITS-1:0] f;
	logic in_range;

	assign en3 = !ctl_s3.valid || take;
	assign en2 = !ctl_s2.valid || en3;
	assign en1 = !ctl_s1.valid || en2;
	assign req.ready = en1;

	always_comb begin
		ctl_in.valid = req.valid;
		ctl_in.query = (req.kind == pft_pkg::KIND_QUERY);
		ctl_in.below = (req.distance < min_distance);
		ctl_in.zero  = 1'b0;
		ctl_in.wr_ok = (32'(req.entry_index) < 32'(TABLE_DEPTH));
	end

	// usable entry count, capped at the table depth
	assign n_ext = KB'(entries_in_use);
	assign n_cap = (n_ext > KB'(TABLE_DEPTH)) ? KB'(TABLE_DEPTH) : n_ext;
	assign lim   = (n_cap >= KB'(2)) ? (n_cap - KB'(1)) : '0;

	assign k  = prod_s2[pft_pkg::PROD_BITS-1 -: KB];
	assign k1 = k + KB'(1);
	assign f  = prod_s2[pft_pkg::POS_FRAC_BITS-1 -: FRAC_BITS];
	assign in_range = (k < lim);

	always_comb begin
		ctl_nx3      = ctl_s2;
		ctl_nx3.zero = ctl_s2.query && !ctl_s2.below && !in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (en1) begin
				ctl_s1 <= ctl_in;
			end
			if (en2) begin
				ctl_s2 <= ctl_s1;
			end
			if (en3) begin
				ctl_s3 <= ctl_nx3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			idx_s1    <= req.entry_index;
			force_s1  <= req.load_force;
			energy_s1 <= req.load_energy;
			pos_s1    <= req.distance - min_distance;
		end
		if (en2) begin
			idx_s2    <= idx_s1;
			force_s2  <= force_s1;
			energy_s2 <= energy_s1;
			prod_s2   <= pft_pkg::PROD_BITS'(pos_s1) * pft_pkg::PROD_BITS'(inverse_step);
		end
		if (en3) begin
			// below the minimum reads entry 0 at full weight
			frac_s3    <= ctl_s2.below ? '0 : f;
			addr_lo_s3 <= ctl_s2.below ? '0 : ADDR_BITS'(k);
			addr_hi_s3 <= ctl_s2.below ? '0 : ADDR_BITS'(k1);
			wr_addr_s3 <= ADDR_BITS'(idx_s2);
			force_s3   <= force_s2;
			energy_s3  <= energy_s2;
		end
	end

	`PFT_ASSERT_NEXT(a_s1_hold, ctl_s1.valid && !en2, ctl_s1.valid && $stable(pos_s1), "stage 1 item changed while stalled")
	`PFT_ASSERT_NEXT(a_s3_hold, ctl_s3.valid && !take, ctl_s3.valid && $stable(addr_lo_s3) && $stable(frac_s3), "stage 3 item changed while stalled")
	`PFT_ASSERT_SAME(a_s3_flags, ctl_s3.valid, !(ctl_s3.zero && ctl_s3.below) && (ctl_s3.query || !ctl_s3.zero), "inconsistent stage 3 flags")

endmodule

@@ rtl/pft_back.sv @@
// ---------------------------------------------------------------------------
// pft_back
// stages 4 to 6: table data, weighted products, sum and result register
// ---------------------------------------------------------------------------
`include "pair_force_table_interpolator_assert.svh"

module pft_back #(
	parameter int VALUE_BITS = pft_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = pft_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pft_pkg::ctl_t         ctl_s3,
	input  logic [FRAC_BITS-1:0]  frac_s3,
	input  logic [VALUE_BITS-1:0] force_lo,
	input  logic [VALUE_BITS-1:0] force_hi,
	input  logic [VALUE_BITS-1:0] energy_lo,
	input  logic [VALUE_BITS-1:0] energy_hi,
	output logic                  take,
	pft_out_if.source             rsp
);

	localparam int W_BITS = FRAC_BITS + 2;
	localparam int P_BITS = VALUE_BITS + W_BITS;
	localparam int S_BITS = P_BITS + 1;
	localparam logic signed [W_BITS-1:0] ONE_W = W_BITS'(1) << FRAC_BITS;

	pft_pkg::ctl_t ctl_s4, ctl_s5, ctl_in4;
	logic v_s6;
	logic en4, en5, en6;

	logic [FRAC_BITS-1:0] frac_s4;
	logic signed [W_BITS-1:0] wa, wb;
	logic signed [VALUE_BITS-1:0] fl, fh, el, eh;
	logic signed [P_BITS-1:0] pf_lo_s5, pf_hi_s5, pe_lo_s5, pe_hi_s5;
	logic signed [S_BITS-1:0] sum_f, sum_e;
	logic signed [VALUE_BITS-1:0] force_s6, energy_s6;

	assign en6  = !v_s6 || rsp.ready;
	assign en5  = !ctl_s5.valid || en6;
	assign en4  = !ctl_s4.valid || en5;
	assign take = en4;

	// loads end at stage 3
	always_comb begin
		ctl_in4       = ctl_s3;
		ctl_in4.valid = ctl_s3.valid && ctl_s3.query;
	end

	assign wb = signed'(W_BITS'(frac_s4));
	assign wa = ONE_W - wb;
	assign fl = signed'(force_lo);
	assign fh = signed'(force_hi);
	assign el = signed'(energy_lo);
	assign eh = signed'(energy_hi);

	// floor of the weighted sum over 2^FRAC_BITS is an arithmetic shift
	assign sum_f = S_BITS'(pf_lo_s5) + S_BITS'(pf_hi_s5);
	assign sum_e = S_BITS'(pe_lo_s5) + S_BITS'(pe_hi_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			v_s6   <= 1'b0;
		end else begin
			if (en4) begin
				ctl_s4 <= ctl_in4;
			end
			if (en5) begin
				ctl_s5 <= ctl_s4;
			end
			if (en6) begin
				v_s6 <= ctl_s5.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			frac_s4 <= frac_s3;
		end
		if (en5) begin
			pf_lo_s5 <= P_BITS'(fl) * P_BITS'(wa);
			pf_hi_s5 <= P_BITS'(fh) * P_BITS'(wb);
			pe_lo_s5 <= P_BITS'(el) * P_BITS'(wa);
			pe_hi_s5 <= P_BITS'(eh) * P_BITS'(wb);
		end
		if (en6) begin
			force_s6  <= ctl_s5.zero ? '0 : sum_f[FRAC_BITS +: VALUE_BITS];
			energy_s6 <= ctl_s5.zero ? '0 : sum_e[FRAC_BITS +: VALUE_BITS];
		end
	end

	assign rsp.valid     = v_s6;
	assign rsp.force_res = force_s6;
	assign rsp.energy    = energy_s6;

	`PFT_ASSERT_NEXT(a_zero_result, en6 && ctl_s5.valid && ctl_s5.zero, v_s6 && force_s6 == '0 && energy_s6 == '0, "out-of-range query gave a nonzero result")

endmodule

@@ rtl/pair_force_table_interpolator.sv @@
// ---------------------------------------------------------------------------
// pair_force_table_interpolator: one item per cycle (loads and queries) while rsp is ready,
// six register stages, two table reads per query from a dual read port ram per table;
// loads write the tables at stage 3
// reset clears valid bits, sets config defaults; data regs and tables are not cleared
// ---------------------------------------------------------------------------
module pair_force_table_interpolator #(
	parameter int TABLE_DEPTH = pft_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_BITS  = pft_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS   = pft_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pft_cfg_if.sink    cfg,
	pft_in_if.sink     req,
	pft_out_if.source  rsp
);

	localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [pft_pkg::DIST_BITS-1:0]  min_distance_q;
	logic [pft_pkg::STEP_BITS-1:0]  inverse_step_q;
	logic [pft_pkg::COUNT_BITS-1:0] entries_in_use_q;

	pft_pkg::ctl_t           ctl_s3;
	logic [FRAC_BITS-1:0]    frac_s3;
	logic [ADDR_BITS-1:0]    addr_lo_s3, addr_hi_s3, wr_addr_s3;
	logic [VALUE_BITS-1:0]   force_s3, energy_s3;
	logic [VALUE_BITS-1:0]   force_lo, force_hi, energy_lo, energy_hi;
	logic                    take, we;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_distance_q   <= pft_pkg::MIN_DISTANCE_RST;
			inverse_step_q   <= pft_pkg::INVERSE_STEP_RST;
			entries_in_use_q <= pft_pkg::ENTRIES_IN_USE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pft_pkg::CFG_MIN_DISTANCE: begin
					min_distance_q <= cfg.data[pft_pkg::DIST_BITS-1:0];
				end
				pft_pkg::CFG_INVERSE_STEP: begin
					inverse_step_q <= cfg.data[pft_pkg::STEP_BITS-1:0];
				end
				pft_pkg::CFG_ENTRIES_IN_USE: begin
					entries_in_use_q <= cfg.data[pft_pkg::COUNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pft_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_BITS  (VALUE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.min_distance   (min_distance_q),
		.inverse_step   (inverse_step_q),
		.entries_in_use (entries_in_use_q),
		.take           (take),
		.ctl_s3         (ctl_s3),
		.frac_s3        (frac_s3),
		.addr_lo_s3     (addr_lo_s3),
		.addr_hi_s3     (addr_hi_s3),
		.wr_addr_s3     (wr_addr_s3),
		.force_s3       (force_s3),
		.energy_s3      (energy_s3)
	);

	// a load writes once, as it leaves stage 3
	assign we = take && ctl_s3.valid && !ctl_s3.query && ctl_s3.wr_ok;

	pft_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_force_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (wr_addr_s3),
		.wdata   (force_s3),
		.re      (take),
		.raddr_a (addr_lo_s3),
		.raddr_b (addr_hi_s3),
		.rdata_a (force_lo),
		.rdata_b (force_hi)
	);

	pft_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_energy_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (wr_addr_s3),
		.wdata   (energy_s3),
		.re      (take),
		.raddr_a (addr_lo_s3),
		.raddr_b (addr_hi_s3),
		.rdata_a (energy_lo),
		.rdata_b (energy_hi)
	);

	pft_back #(
		.VALUE_BITS (VALUE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.frac_s3   (frac_s3),
		.force_lo  (force_lo),
		.force_hi  (force_hi),
		.energy_lo (energy_lo),
		.energy_hi (energy_hi),
		.take      (take),
		.rsp       (rsp)
	);

endmodule
